// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Both sample on the rising edge of clk_i; the first is masked while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that is checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/rfpcd_pkg.sv
package rfpcd_pkg;

  // Default width of the edge-to-edge gap arithmetic.
  localparam int unsigned GAP_WIDTH_DEF = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] MIN_SYNC_RST = 16'd5000;
  localparam logic [5:0]  CODE_LEN_RST = 6'd24;

  // Bit counter value that marks the sync search.
  localparam logic [5:0] SYNC_MARK    = 6'd63;
  localparam logic [5:0] MAX_CODE_LEN = 6'd32;

  // The sync gap spans 31 units: 31 * x is (x << 5) - x.
  localparam int unsigned SYNC_RATIO = 31;
  localparam int unsigned SYNC_SHIFT = 5;

  // A long pulse spans 3 units: 3 * x is (x << 1) + x.
  localparam int unsigned LONG_SHIFT = 1;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_MIN_SYNC = 1'b0,
    REG_CODE_LEN = 1'b1
  } reg_idx_e;

  // One item handed from the input register to the decoder.
  typedef struct packed {
    logic        go;
    opcode_e     opcode;
    logic [31:0] edge_time;
  } step_t;

  // Configuration seen by the decoder.
  typedef struct packed {
    logic [15:0] min_sync;
    logic [5:0]  code_len;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic        code_valid;
    logic [31:0] code;
    logic        ready_res;
  } result_t;

endpackage

// File: hdl/rf_remote_pulse_code_decoder_unit.sv
// Pulse-width code decoder for a 433 MHz remote.
// Input stream: tdata carries the microsecond time of a line edge, tuser the
// operation (0 = edge, 1 = read and consume the held code). Every transfer,
// edge or read, produces exactly one output transfer: tdata is the code (zero
// unless a read took a held code), tuser[0] marks a returned code and tuser[1]
// tells whether a code is still held after that item.
// The decoder looks for a sync gap of about 31 units, then decodes pairs of
// gaps into bits until the configured code length is reached.
// Configuration: APB port, min_sync_length at 0x0, code_length at 0x4; write
// only while the stream is idle. pready is always high.
// An accepted item goes through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the whole
// decode step for an item is one pass from the input register to the result
// register; the unit pulse is one reciprocal multiply in the cycle after sync.
// Reset clears the decoder to sync search with nothing held and restores the
// register defaults. When the output is stalled, one more item is taken into
// the input register, then s_axis_tready falls until the result is taken.
module rf_remote_pulse_code_decoder_unit #(
  parameter int unsigned GAP_WIDTH = rfpcd_pkg::GAP_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] edge_time_us
  input  logic        s_axis_tuser,   // [0] opcode
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] code
  output logic [1:0]  m_axis_tuser,   // [0] code_valid, [1] ready_res
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                in_valid_q;
  rfpcd_pkg::opcode_e  in_op_q;
  logic [31:0]         in_time_q;
  logic                out_valid_q;
  rfpcd_pkg::result_t  out_res_q;
  logic                advance;
  logic [15:0]         min_sync_q;
  logic [5:0]          code_len_q;
  logic                cfg_wr;
  rfpcd_pkg::reg_idx_e cfg_idx;
  rfpcd_pkg::step_t    step;
  rfpcd_pkg::cfg_t     cfg;
  rfpcd_pkg::result_t  res;

  // The item in the input register moves on when the result slot is free.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= rfpcd_pkg::opcode_e'(s_axis_tuser);
      in_time_q <= s_axis_tdata;
    end
  end

  // Decoder.
  assign step.go        = advance;
  assign step.opcode    = in_op_q;
  assign step.edge_time = in_time_q;
  assign cfg.min_sync   = min_sync_q;
  assign cfg.code_len   = code_len_q;

  rfpcd_core #(
    .GAP_WIDTH (GAP_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.code;
  assign m_axis_tuser  = {out_res_q.ready_res, out_res_q.code_valid};

  // Configuration registers; the word address selects the register.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rfpcd_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sync_q <= rfpcd_pkg::MIN_SYNC_RST;
      code_len_q <= rfpcd_pkg::CODE_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rfpcd_pkg::REG_MIN_SYNC: min_sync_q <= pwdata[15:0];
        rfpcd_pkg::REG_CODE_LEN: code_len_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      rfpcd_pkg::REG_MIN_SYNC: prdata = 32'(min_sync_q);
      rfpcd_pkg::REG_CODE_LEN: prdata = 32'(code_len_q);
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: hdl/rfpcd_core.sv
module rfpcd_core #(
  parameter int unsigned GAP_WIDTH = rfpcd_pkg::GAP_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfpcd_pkg::step_t   step_i,
  input  rfpcd_pkg::cfg_t    cfg_i,
  output rfpcd_pkg::result_t res_o
);

  // Exact reciprocal of 31 for GAP_WIDTH-bit dividends:
  // floor(x / 31) == (x * RECIP) >> (GAP_WIDTH + 5).
  localparam int unsigned RECIP_SHIFT = GAP_WIDTH + rfpcd_pkg::SYNC_SHIFT;
  localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;
  localparam logic [GAP_WIDTH:0] RECIP =
    (GAP_WIDTH + 1)'(RECIP_ONE / 64'(rfpcd_pkg::SYNC_RATIO) + 64'd1);
  localparam int unsigned PROD_WIDTH = 2 * GAP_WIDTH + 1;

  // Decoder state.
  logic [5:0]           bit_count_q, bit_count_d;
  logic [GAP_WIDTH-1:0] unit_q, unit_d;
  logic [31:0]          last_edge_q, last_edge_d;
  logic [GAP_WIDTH-1:0] prev_gap_q, prev_gap_d;
  logic [GAP_WIDTH-1:0] first_q, first_d;
  logic [31:0]          shift_q, shift_d;
  logic [31:0]          held_code_q, held_code_d;
  logic                 held_q, held_d;

  // The unit pulse is worked out in the cycle after a sync hit; the edge that follows
  // sync does not need it, since that edge always fills the first half of a bit.
  logic                 div_pend_q, div_pend_d;
  logic [GAP_WIDTH-1:0] div_gap_q, div_gap_d;
  logic [PROD_WIDTH-1:0] div_prod;
  logic [GAP_WIDTH-1:0]  div_quot;

  logic [31:0]          time_diff;
  logic [GAP_WIDTH-1:0] gap;
  logic [GAP_WIDTH-1:0] min_sync_ext;
  logic [GAP_WIDTH-1:0] s_quarter, s_lo_base, s_hi_base, s_lo, s_hi;
  logic [GAP_WIDTH-1:0] u_quarter, u_lo, u_hi, u_lo3, u_hi3;
  logic                 sync_ok, one_ok, zero_ok;
  logic [5:0]           eff_len;
  logic [5:0]           bit_inc;
  rfpcd_pkg::result_t   res;

  // Gap since the previous edge, truncated to the gap width.
  assign time_diff    = step_i.edge_time - last_edge_q;
  assign gap          = time_diff[GAP_WIDTH-1:0];
  assign min_sync_ext = GAP_WIDTH'(cfg_i.min_sync);

  // Sync window: 31 times the previous gap, plus or minus a quarter; all wraps.
  assign s_quarter = prev_gap_q >> 2;
  assign s_lo_base = prev_gap_q - s_quarter;
  assign s_hi_base = prev_gap_q + s_quarter;
  assign s_lo      = (s_lo_base << rfpcd_pkg::SYNC_SHIFT) - s_lo_base;
  assign s_hi      = (s_hi_base << rfpcd_pkg::SYNC_SHIFT) - s_hi_base;
  assign sync_ok   = (gap > min_sync_ext) && (prev_gap_q != '0) &&
                     (gap > s_lo) && (gap < s_hi);

  // Short and long pulse windows around the unit pulse.
  assign u_quarter = unit_q >> 2;
  assign u_lo      = unit_q - u_quarter;
  assign u_hi      = unit_q + u_quarter;
  assign u_lo3     = (u_lo << rfpcd_pkg::LONG_SHIFT) + u_lo;
  assign u_hi3     = (u_hi << rfpcd_pkg::LONG_SHIFT) + u_hi;

  // Long then short is a one; short then long is a zero.
  assign one_ok  = (first_q > u_lo3) && (first_q < u_hi3) && (gap > u_lo) && (gap < u_hi);
  assign zero_ok = (gap > u_lo3) && (gap < u_hi3) && (first_q > u_lo) && (first_q < u_hi);

  // A code length of zero or above the word width means a full word.
  assign eff_len = ((cfg_i.code_len == '0) || (cfg_i.code_len > rfpcd_pkg::MAX_CODE_LEN)) ?
                   rfpcd_pkg::MAX_CODE_LEN : cfg_i.code_len;
  assign bit_inc = bit_count_q + 6'd1;

  // Unit pulse from the registered sync gap.
  assign div_prod = PROD_WIDTH'(div_gap_q) * PROD_WIDTH'(RECIP);
  assign div_quot = GAP_WIDTH'(div_prod[PROD_WIDTH-1:RECIP_SHIFT]);

  // Next state and result for the item in the input register.
  always_comb begin
    bit_count_d = bit_count_q;
    unit_d      = unit_q;
    last_edge_d = last_edge_q;
    prev_gap_d  = prev_gap_q;
    first_d     = first_q;
    shift_d     = shift_q;
    held_code_d = held_code_q;
    held_d      = held_q;
    div_pend_d  = 1'b0;
    div_gap_d   = div_gap_q;
    res         = '0;

    if (div_pend_q) begin
      unit_d = div_quot;
    end

    if (step_i.go) begin
      case (step_i.opcode)
        rfpcd_pkg::OP_READ: begin
          if (held_q) begin
            res.code_valid = 1'b1;
            res.code       = held_code_q;
            held_d         = 1'b0;
          end
        end
        rfpcd_pkg::OP_EDGE: begin
          // Edges are dropped entirely while a code waits to be read.
          if (!held_q) begin
            last_edge_d = step_i.edge_time;
            if (bit_count_q == rfpcd_pkg::SYNC_MARK) begin
              if (sync_ok) begin
                div_pend_d  = 1'b1;
                div_gap_d   = gap;
                prev_gap_d  = '0;
                bit_count_d = '0;
              end else begin
                prev_gap_d = gap;
              end
            end else if (first_q == '0) begin
              // An empty first half takes this gap.
              first_d = gap;
            end else begin
              first_d = '0;
              if (one_ok) begin
                shift_d     = {shift_q[30:0], 1'b1};
                bit_count_d = bit_inc;
              end else if (zero_ok) begin
                shift_d     = {shift_q[30:0], 1'b0};
                bit_count_d = bit_inc;
              end else begin
                bit_count_d = rfpcd_pkg::SYNC_MARK;
                shift_d     = '0;
                unit_d      = '0;
              end
              // Word complete: hold it and search for sync again.
              if (bit_count_d == eff_len) begin
                held_code_d = shift_d;
                held_d      = 1'b1;
                bit_count_d = rfpcd_pkg::SYNC_MARK;
                shift_d     = '0;
                unit_d      = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    res.ready_res = held_d;
  end

  assign res_o = res;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= rfpcd_pkg::SYNC_MARK;
      unit_q      <= '0;
      last_edge_q <= '0;
      prev_gap_q  <= '0;
      first_q     <= '0;
      shift_q     <= '0;
      held_code_q <= '0;
      held_q      <= 1'b0;
      div_pend_q  <= 1'b0;
    end else begin
      bit_count_q <= bit_count_d;
      unit_q      <= unit_d;
      last_edge_q <= last_edge_d;
      prev_gap_q  <= prev_gap_d;
      first_q     <= first_d;
      shift_q     <= shift_d;
      held_code_q <= held_code_d;
      held_q      <= held_d;
      div_pend_q  <= div_pend_d;
    end
  end

  // Divider operand.
  always_ff @(posedge clk_i) begin
    div_gap_q <= div_gap_d;
  end

endmodule

// File: hdl/rfpcd_checker.sv
`include "assert_macros.svh"

module rfpcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic        m_stall;
  logic        code_back;
  logic        no_code;
  logic [33:0] m_payload;

  // Output-side terms used by the properties below.
  assign m_stall   = m_axis_tvalid && !m_axis_tready;
  assign code_back = m_axis_tvalid && m_axis_tuser[0];
  assign no_code   = m_axis_tvalid && !m_axis_tuser[0];
  assign m_payload = {m_axis_tuser, m_axis_tdata};

  // No result is offered in the cycle after reset has been seen.
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result offered in reset")

  // A stalled result holds its payload.
  `ASSERT_CLK(a_stall_hold, m_stall |=> m_axis_tvalid && $stable(m_payload), "stalled result changed")

  // With the result slot empty the input side is never blocked.
  `ASSERT_CLK(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input blocked, output empty")

  // A returned code consumes the held code.
  `ASSERT_CLK(a_read_clears, code_back |-> !m_axis_tuser[1], "code still held after read")

  // Without a returned code the code field is zero.
  `ASSERT_CLK(a_no_code_zero, no_code |-> m_axis_tdata == 32'd0, "code without valid")

endmodule

bind rf_remote_pulse_code_decoder_unit rfpcd_checker u_rfpcd_checker (.*);
